FILE: src/csra_pkg.sv
`timescale 1ns / 1ps
package csra_pkg;

  localparam int VECTOR_SIZE = 4096;
  localparam int ADDR_W = $clog2(VECTOR_SIZE);
  localparam int IDX_W = 24;
  localparam logic [IDX_W-1:0] VECTOR_SIZE_IDX = IDX_W'(VECTOR_SIZE);
  localparam int VAL_W = 32;
  localparam int SUM_W = 48;
  localparam int FRAC_W = 16;
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);

  typedef enum logic [1:0] {
    OP_LOAD = 2'd0,
    OP_NONZERO = 2'd1,
    OP_RESTART = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_OK = 2'd0,
    ST_BELOW = 2'd1,
    ST_BEYOND = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    KIND_LOAD,
    KIND_MAC,
    KIND_RESTART,
    KIND_ERROR
  } kind_t;

  typedef struct packed {
    kind_t kind;
    logic [ADDR_W-1:0] addr;
    logic signed [VAL_W-1:0] value;
    logic first;
    logic last;
    logic signed [SUM_W-1:0] prior;
    status_t status;
  } item_t;

endpackage

FILE: src/csra_front.sv
`timescale 1ns / 1ps
module csra_front import csra_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic [IDX_W-1:0] cfg_wdata,
  input  logic accept,
  input  logic [1:0] opcode,
  input  logic [IDX_W-1:0] index,
  input  logic signed [VAL_W-1:0] value,
  input  logic first_in_row,
  input  logic last_in_row,
  input  logic signed [SUM_W-1:0] prior_sum,
  output logic push,
  output item_t item
);

  logic [IDX_W-1:0] first_row;
  logic halted;
  logic halted_next;
  logic [IDX_W-1:0] offset;

  assign offset = index - first_row;

  always_comb begin
    push = 1'b0;
    halted_next = halted;
    item.kind = KIND_MAC;
    item.addr = offset[ADDR_W-1:0];
    item.value = value;
    item.first = first_in_row;
    item.last = last_in_row;
    item.prior = prior_sum;
    item.status = ST_OK;
    if (accept) begin
      case (op_t'(opcode))
        OP_RESTART: begin
          push = 1'b1;
          item.kind = KIND_RESTART;
          halted_next = 1'b0;
        end
        OP_LOAD: begin
          item.kind = KIND_LOAD;
          item.addr = index[ADDR_W-1:0];
          push = !halted && (index < VECTOR_SIZE_IDX);
        end
        OP_NONZERO: begin
          if (!halted) begin
            push = 1'b1;
            if (index < first_row) begin
              item.kind = KIND_ERROR;
              item.status = ST_BELOW;
              halted_next = 1'b1;
            end else if (offset >= VECTOR_SIZE_IDX) begin
              item.kind = KIND_ERROR;
              item.status = ST_BEYOND;
              halted_next = 1'b1;
            end
          end
        end
        default: begin
          push = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      halted <= 1'b0;
      first_row <= '0;
    end else begin
      halted <= halted_next;
      if (cfg_we) begin
        first_row <= cfg_wdata;
      end
    end
  end

endmodule

FILE: src/csra_queue.sv
`timescale 1ns / 1ps
module csra_queue import csra_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  item_t push_item,
  input  logic pop,
  output item_t head,
  output logic empty,
  output logic full
);

  item_t slots [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0] count;

  assign empty = (count == '0);
  assign full = (count == (QPTR_W+1)'(QDEPTH));
  assign head = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

FILE: src/csra_back.sv
`timescale 1ns / 1ps
module csra_back import csra_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  item_t head,
  input  logic empty,
  output logic pop,
  output logic m_tvalid,
  input  logic m_tready,
  output logic signed [SUM_W-1:0] row_sum,
  output status_t status
);

  localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

  logic [VAL_W-1:0] vector_store [VECTOR_SIZE];

  logic en;
  logic v1;
  item_t it1;
  logic signed [VAL_W-1:0] x1;
  logic v2;
  item_t it2;
  logic signed [2*VAL_W-1:0] prod2;
  logic signed [SUM_W-1:0] acc;

  logic signed [SUM_W-1:0] scaled;
  logic signed [SUM_W-1:0] base;
  logic signed [SUM_W:0] wide_sum;
  logic signed [SUM_W-1:0] sat_sum;

  assign en = !m_tvalid || m_tready;
  assign pop = en && !empty;

  // read during write returns the old word, only loads write
  always_ff @(posedge clk) begin
    if (pop) begin
      if (head.kind == KIND_LOAD) begin
        vector_store[head.addr] <= head.value;
      end
      x1 <= vector_store[head.addr];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      it1 <= head;
      it2 <= it1;
      prod2 <= (2*VAL_W)'(it1.value) * (2*VAL_W)'(x1);
    end
  end

  // floor shift of the q32.32 product to q32.16 is a plain bit select
  assign scaled = prod2[2*VAL_W-1:FRAC_W];
  assign base = it2.first ? it2.prior : acc;
  assign wide_sum = {base[SUM_W-1], base} + {scaled[SUM_W-1], scaled};

  always_comb begin
    if (wide_sum[SUM_W] != wide_sum[SUM_W-1]) begin
      sat_sum = wide_sum[SUM_W] ? SUM_MIN : SUM_MAX;
    end else begin
      sat_sum = wide_sum[SUM_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      acc <= '0;
      m_tvalid <= 1'b0;
    end else if (en) begin
      v1 <= !empty;
      v2 <= v1;
      m_tvalid <= 1'b0;
      if (v2) begin
        case (it2.kind)
          KIND_MAC: begin
            acc <= sat_sum;
            m_tvalid <= it2.last;
          end
          KIND_RESTART: begin
            acc <= '0;
          end
          KIND_ERROR: begin
            m_tvalid <= 1'b1;
          end
          default: begin
            acc <= acc;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en && v2) begin
      if (it2.kind == KIND_ERROR) begin
        row_sum <= '0;
        status <= it2.status;
      end else begin
        row_sum <= sat_sum;
        status <= ST_OK;
      end
    end
  end

endmodule

FILE: src/csr_spmv_row_accumulator.sv
`timescale 1ns / 1ps
// channel   dir  handshake                 payload
// s_*       in   s_tvalid / s_tready       tdata index,value,prior_sum; tuser opcode,first
// m_*       out  m_tvalid / m_tready       tdata row_sum; tuser status
// cfg_*     in   cfg_we                    cfg_wdata first_row
//
// one word per cycle in while the queue is not full, and out while m_* is not stalled
// path: queue write at accept, then vector store read, multiply, accumulate into the output register
// rst is synchronous: clears halt, accumulator, first_row, queue and valids
// a stalled m_* freezes the back pipeline; the four-deep queue absorbs s_* until full
module csr_spmv_row_accumulator import csra_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic [IDX_W-1:0] cfg_wdata,
  input  logic s_tvalid,
  output logic s_tready,
  input  logic [103:0] s_tdata,   // index[23:0], value[55:24], prior_sum[103:56]
  input  logic [2:0] s_tuser,     // opcode[1:0], first_in_row[2]
  input  logic s_tlast,
  output logic m_tvalid,
  input  logic m_tready,
  output logic [47:0] m_tdata,    // row_sum[47:0]
  output logic [1:0] m_tuser      // status[1:0]
);

  logic accept;
  logic push;
  item_t push_item;
  logic pop;
  item_t head;
  logic empty;
  logic full;
  logic signed [SUM_W-1:0] row_sum;
  status_t status;

  assign s_tready = !full;
  assign accept = s_tvalid && s_tready;
  assign m_tdata = row_sum;
  assign m_tuser = status;

  csra_front u_front (
    .clk (clk),
    .rst (rst),
    .cfg_we (cfg_we),
    .cfg_wdata (cfg_wdata),
    .accept (accept),
    .opcode (s_tuser[1:0]),
    .index (s_tdata[23:0]),
    .value (s_tdata[55:24]),
    .first_in_row (s_tuser[2]),
    .last_in_row (s_tlast),
    .prior_sum (s_tdata[103:56]),
    .push (push),
    .item (push_item)
  );

  csra_queue u_queue (
    .clk (clk),
    .rst (rst),
    .push (push),
    .push_item (push_item),
    .pop (pop),
    .head (head),
    .empty (empty),
    .full (full)
  );

  csra_back u_back (
    .clk (clk),
    .rst (rst),
    .head (head),
    .empty (empty),
    .pop (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .row_sum (row_sum),
    .status (status)
  );

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) !(push && full))
    else $error("queue push while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst) !(pop && empty))
    else $error("queue pop while empty");

  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser != ST_OK) |-> (m_tdata == '0))
    else $error("error result with nonzero sum");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (full && !pop) |=> !s_tready)
    else $error("queue drained without a pop");

endmodule

FILE: sim/tb.sv
`timescale 1ns / 1ps
module tb;
  import csra_pkg::*;

  typedef struct packed {
    logic [SUM_W-1:0] sum;
    status_t status;
  } row_out_t;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam longint SUM_MAX = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint SUM_MIN = -SUM_MAX - 1;
  localparam logic [IDX_W-1:0] IDX_MAX = 24'hFF_FFFF;
  localparam int SETTLE_CYCLES = 16;
  localparam int LIMIT_CYCLES = 300000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [IDX_W-1:0] cfg_wdata = '0;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [103:0] s_tdata = '0;   // index[23:0], value[55:24], prior_sum[103:56]
  logic [2:0] s_tuser = '0;     // opcode[1:0], first_in_row[2]
  logic s_tlast = 1'b0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [47:0] m_tdata;         // row_sum[47:0]
  logic [1:0] m_tuser;          // status[1:0]

  // predicted block state
  logic signed [VAL_W-1:0] vec_mem [VECTOR_SIZE];
  bit vec_written [VECTOR_SIZE];
  int written_addrs[$];
  longint acc = 0;
  bit halted = 1'b0;
  logic [IDX_W-1:0] first_row = '0;
  row_out_t rows_due[$];

  int errors = 0;
  int cycles = 0;
  int gap_pct = 0;
  int stall_pct = 0;

  csr_spmv_row_accumulator dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .s_tlast(s_tlast),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT_CYCLES) begin
      $display("Some tests failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= stall_pct);
  end

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    if (errors < 100)
      $display("%0t mismatch %s: got %h want %h", $time, what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin : result_check
    row_out_t due;
    if (!rst && m_tvalid && m_tready) begin
      if (rows_due.size() == 0) begin
        report_mismatch("word with no row pending", 64'(m_tdata), '0);
      end else begin
        due = rows_due.pop_front();
        if (m_tdata !== due.sum)
          report_mismatch("row_sum", 64'(m_tdata), 64'(due.sum));
        if (m_tuser !== due.status)
          report_mismatch("status", 64'(m_tuser), 64'(due.status));
      end
    end
  end

  function automatic void predict_row_step(logic [1:0] op, logic [IDX_W-1:0] idx,
                                           logic signed [VAL_W-1:0] val, bit first,
                                           bit last, logic signed [SUM_W-1:0] prior);
    longint off;
    longint x;
    longint prod;
    if (op == OP_RESTART) begin
      halted = 1'b0;
      acc = 0;
      return;
    end
    if (op == OP_UNUSED || halted) return;
    if (op == OP_LOAD) begin
      if (idx < VECTOR_SIZE) begin
        vec_mem[idx[ADDR_W-1:0]] = val;
        if (!vec_written[idx[ADDR_W-1:0]]) begin
          vec_written[idx[ADDR_W-1:0]] = 1'b1;
          written_addrs.push_back(int'(idx));
        end
      end
      return;
    end
    if (idx < first_row) begin
      halted = 1'b1;
      rows_due.push_back('{sum: '0, status: ST_BELOW});
      return;
    end
    off = longint'(idx) - longint'(first_row);
    if (off >= VECTOR_SIZE) begin
      halted = 1'b1;
      rows_due.push_back('{sum: '0, status: ST_BEYOND});
      return;
    end
    x = longint'(vec_mem[off[ADDR_W-1:0]]);
    prod = (longint'(val) * x) >>> FRAC_W;
    if (first) acc = longint'(prior);
    acc = acc + prod;
    if (acc > SUM_MAX) acc = SUM_MAX;
    else if (acc < SUM_MIN) acc = SUM_MIN;
    if (last) rows_due.push_back('{sum: acc[SUM_W-1:0], status: ST_OK});
  endfunction

  task automatic send_word(logic [1:0] op, logic [IDX_W-1:0] idx, logic [VAL_W-1:0] val,
                           bit first, bit last, logic [SUM_W-1:0] prior);
    while ($urandom_range(99) < gap_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {prior, val, idx};
    s_tuser <= {first, op};
    s_tlast <= last;
    do @(posedge clk); while (!s_tready);
    predict_row_step(op, idx, val, first, last, prior);
  endtask

  task automatic wait_idle();
    s_tvalid <= 1'b0;
    stall_pct = 0;
    while (rows_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_first_row(logic [IDX_W-1:0] v);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    first_row = v;
  endtask

  function automatic logic [VAL_W-1:0] rand_q16();
    case ($urandom_range(3))
      0: return $urandom();
      1, 2: return 32'($urandom_range(32'h000F_FFFF)) - 32'h0007_FFFF;
      default: begin
        case ($urandom_range(3))
          0: return 32'h8000_0000;
          1: return 32'h7FFF_FFFF;
          2: return 32'hFFFF_FFFF;
          default: return 32'h0001_0000;
        endcase
      end
    endcase
  endfunction

  function automatic logic [SUM_W-1:0] rand_prior();
    int s;
    case ($urandom_range(3))
      0: return 48'({$urandom(), $urandom()});
      1: begin
        s = int'($urandom_range(32'h00FF_FFFF)) - 32'sh007F_FFFF;
        return 48'(longint'(s));
      end
      2: return 48'h7FFF_FFFF_0000 + 48'($urandom_range(32'hFFFF));
      default: return 48'h8000_0000_0000 + 48'($urandom_range(32'hFFFF));
    endcase
  endfunction

  // column that hits a written store entry under the current first_row
  function automatic bit pick_column(output logic [IDX_W-1:0] col);
    longint room;
    int a;
    room = longint'(IDX_MAX) - longint'(first_row);
    col = '0;
    if (written_addrs.size() == 0) return 1'b0;
    for (int i = 0; i < 8; i++) begin
      a = written_addrs[$urandom_range(written_addrs.size() - 1)];
      if (a <= room) begin
        col = first_row + IDX_W'(a);
        return 1'b1;
      end
    end
    foreach (written_addrs[i]) begin
      if (written_addrs[i] <= room) begin
        col = first_row + IDX_W'(written_addrs[i]);
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic logic [IDX_W-1:0] bad_column();
    longint lo;
    lo = longint'(first_row) + VECTOR_SIZE;
    if (first_row != 0 && ($urandom_range(1) == 0 || lo > longint'(IDX_MAX)))
      return IDX_W'($urandom_range(int'(first_row) - 1));
    if ($urandom_range(1) == 0) return IDX_W'(lo);
    return IDX_W'($urandom_range(32'(IDX_MAX), 32'(lo)));
  endfunction

  task automatic test_row_sums();
    gap_pct = 0;
    stall_pct = 0;
    send_word(OP_LOAD, 24'd0, 32'h0001_0000, 1'b0, 1'b0, '0);
    send_word(OP_LOAD, 24'd4095, 32'h8000_0000, 1'b0, 1'b0, '0);
    send_word(OP_LOAD, 24'd1, 32'h7FFF_FFFF, 1'b0, 1'b0, '0);
    send_word(OP_LOAD, 24'd2, 32'hFFFF_8000, 1'b0, 1'b0, '0);
    // single nonzero row
    send_word(OP_NONZERO, 24'd0, 32'h0002_0000, 1'b1, 1'b1, 48'h0000_0003_0000);
    // three word row, max prior, negative floor, largest product
    send_word(OP_NONZERO, 24'd1, 32'h7FFF_FFFF, 1'b1, 1'b0, 48'h7FFF_FFFF_FFFF);
    send_word(OP_NONZERO, 24'd2, 32'h0000_0001, 1'b0, 1'b0, 48'h1234_5678_9ABC);
    send_word(OP_NONZERO, 24'd4095, 32'h8000_0000, 1'b0, 1'b1, '0);
    // negative saturation
    send_word(OP_NONZERO, 24'd4095, 32'h7FFF_FFFF, 1'b1, 1'b1, 48'h8000_0000_0000);
    // unmarked word then row end without a start
    send_word(OP_NONZERO, 24'd0, 32'hFFFF_FFFF, 1'b0, 1'b0, 48'hFFFF_FFFF_FFFF);
    send_word(OP_NONZERO, 24'd0, 32'h0000_8000, 1'b0, 1'b1, '0);
    wait_idle();
  endtask

  task automatic test_column_errors();
    write_first_row(24'd16);
    send_word(OP_NONZERO, 24'd15, 32'h0001_0000, 1'b1, 1'b1, '0);
    // halted: both ignored
    send_word(OP_LOAD, 24'd3, 32'h0005_0000, 1'b0, 1'b0, '0);
    send_word(OP_NONZERO, 24'd16, 32'h0001_0000, 1'b1, 1'b1, 48'h0000_0001_0000);
    send_word(OP_RESTART, 24'hAB_CDEF, 32'h1234_5678, 1'b1, 1'b1, 48'hFFFF_0000_FFFF);
    send_word(OP_NONZERO, 24'd16, 32'h0003_0000, 1'b0, 1'b1, 48'h0000_7777_0000);
    send_word(OP_NONZERO, 24'd16 + 24'(VECTOR_SIZE), 32'h0001_0000, 1'b1, 1'b1, '0);
    send_word(OP_RESTART, '0, '0, 1'b0, 1'b0, '0);
    send_word(OP_LOAD, IDX_MAX, 32'hDEAD_BEEF, 1'b0, 1'b0, '0);
    send_word(OP_UNUSED, 24'd0, 32'h0001_0000, 1'b1, 1'b1, '0);
    wait_idle();
  endtask

  task automatic test_first_row_extremes();
    write_first_row(IDX_MAX);
    send_word(OP_NONZERO, IDX_MAX, 32'hFFFE_0000, 1'b1, 1'b1, 48'h0000_0010_0000);
    send_word(OP_NONZERO, 24'd0, 32'h0001_0000, 1'b1, 1'b1, '0);
    send_word(OP_RESTART, '0, '0, 1'b0, 1'b0, '0);
    wait_idle();
    write_first_row('0);
    send_word(OP_NONZERO, IDX_MAX, 32'h0001_0000, 1'b1, 1'b1, '0);
    send_word(OP_RESTART, '0, '0, 1'b0, 1'b0, '0);
    wait_idle();
  endtask

  task automatic run_random_phase(int n_words, int gap, int stall, logic [IDX_W-1:0] fr);
    int sent;
    int r;
    int len;
    bit first;
    bit last;
    logic [IDX_W-1:0] col;
    write_first_row(fr);
    gap_pct = gap;
    stall_pct = stall;
    sent = 0;
    while (sent < n_words) begin
      r = $urandom_range(99);
      if (halted) begin
        if (r < 60) begin
          send_word(OP_RESTART, 24'($urandom()), rand_q16(), 1'($urandom_range(1)),
                    1'($urandom_range(1)), rand_prior());
          sent++;
        end else begin
          send_word(r < 80 ? OP_LOAD : OP_NONZERO, 24'($urandom()), rand_q16(),
                    1'($urandom_range(1)), 1'($urandom_range(1)), rand_prior());
        end
      end else if (r < 12) begin
        if ($urandom_range(9) == 0)
          col = IDX_W'($urandom_range(32'(IDX_MAX), VECTOR_SIZE));
        else
          col = IDX_W'($urandom_range(VECTOR_SIZE - 1));
        send_word(OP_LOAD, col, rand_q16(), 1'($urandom_range(1)), 1'($urandom_range(1)),
                  rand_prior());
        sent++;
      end else if (r < 14) begin
        send_word(OP_UNUSED, 24'($urandom()), rand_q16(), 1'($urandom_range(1)),
                  1'($urandom_range(1)), rand_prior());
      end else if (r < 16) begin
        send_word(OP_RESTART, 24'($urandom()), rand_q16(), 1'($urandom_range(1)),
                  1'($urandom_range(1)), rand_prior());
        sent++;
      end else if (r < 19) begin
        send_word(OP_NONZERO, bad_column(), rand_q16(), 1'($urandom_range(1)),
                  1'($urandom_range(1)), rand_prior());
        sent++;
      end else begin
        len = $urandom_range(6, 1);
        for (int k = 0; k < len && !halted; k++) begin
          if ($urandom_range(99) < 2 || !pick_column(col)) col = bad_column();
          first = (k == 0);
          last = (k == len - 1);
          // broken row marks
          if ($urandom_range(19) == 0) begin
            first = 1'($urandom_range(1));
            last = 1'($urandom_range(1));
          end
          send_word(OP_NONZERO, col, rand_q16(), first, last, rand_prior());
          sent++;
        end
      end
    end
    wait_idle();
  endtask

  task automatic test_random_traffic();
    run_random_phase(125, 0, 0, '0);
    run_random_phase(125, 53, 0, IDX_W'($urandom_range(255)));
    run_random_phase(125, 0, 53, IDX_W'($urandom()));
    run_random_phase(125, 13, 13, IDX_MAX);
    run_random_phase(125, 0, 0, IDX_W'($urandom_range(VECTOR_SIZE)));
    run_random_phase(125, 53, 0, IDX_W'($urandom()));
    run_random_phase(125, 0, 53, '0);
    run_random_phase(125, 13, 13, IDX_W'($urandom_range(32'(IDX_MAX), 32'hF0_0000)));
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_row_sums();
    test_column_errors();
    test_first_row_extremes();
    test_random_traffic();
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
